[design/line_intersection_defines.svh]
// Assertion macros used by the line intersection top level.
`ifndef LINE_INTERSECTION_DEFINES_SVH
`define LINE_INTERSECTION_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define LI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_intersection: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_intersection: next-cycle check failed");

`else

`define LI_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LI_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[design/lisect_pkg.sv]
// Shared types and constants for the line intersection pipeline.
`timescale 1ns / 1ps

package lisect_pkg;

  // Width of every coefficient and coordinate port of the top level.
  localparam int FIELD_W = 32;

  // Control flags that travel with each request down the pipeline.
  typedef struct packed {
    logic valid;
    logic parallel;
    logic neg_x;
    logic neg_y;
    logic high_x;
    logic high_y;
  } lisect_ctrl_t;

endpackage

[design/line_intersection.sv]
// Top level of the two-line intersection unit (Cramer's rule, fixed point).
//
// Usage: present two lines a1*y + a2*x = b (signed Q16.16 by default) on the
// coefficient ports with start high. A request is taken on every rising edge
// at which start is high and busy is low; busy is always low, so a new
// request may be issued in every cycle.
// Each request yields one result, shown for a single cycle with done high:
// cross_x, cross_y, is_parallel and overflowed. The receiver cannot hold a
// result off and must take it in that cycle.
// From the accepting edge to the done cycle a request passes five front-end
// stages (capture, products, differences, magnitudes, range check), one
// division cell per quotient bit, and the output register. Throughput is one
// request per cycle, set by the chain of division cells, each of which
// settles one quotient bit.
// Parallel lines give zero coordinates with is_parallel set; a quotient
// outside the coordinate range saturates and sets overflowed.
// Synchronous reset empties the pipeline: requests in flight are dropped and
// done stays low until new requests have passed through.
`timescale 1ns / 1ps
`include "line_intersection_defines.svh"

module line_intersection #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [lisect_pkg::FIELD_W-1:0] first_y_coef,
  input  logic signed [lisect_pkg::FIELD_W-1:0] first_x_coef,
  input  logic signed [lisect_pkg::FIELD_W-1:0] first_offset,
  input  logic signed [lisect_pkg::FIELD_W-1:0] second_y_coef,
  input  logic signed [lisect_pkg::FIELD_W-1:0] second_x_coef,
  input  logic signed [lisect_pkg::FIELD_W-1:0] second_offset,
  output logic                                  done,
  output logic signed [lisect_pkg::FIELD_W-1:0] cross_x,
  output logic signed [lisect_pkg::FIELD_W-1:0] cross_y,
  output logic                                  is_parallel,
  output logic                                  overflowed
);

  localparam int MAG_W = 2 * COEF_WIDTH;
  localparam int EXT_W = (FRAC_BITS > COEF_WIDTH) ? FRAC_BITS : COEF_WIDTH;
  localparam int REM_W = MAG_W + EXT_W;
  localparam int CW    = COEF_WIDTH;

  lisect_pkg::lisect_ctrl_t ctrl_c  [CW+1];
  logic [MAG_W-1:0]         den_c   [CW+1];
  logic [REM_W-1:0]         rem_x_c [CW+1];
  logic [REM_W-1:0]         rem_y_c [CW+1];
  logic [CW-1:0]            quo_x_c [CW+1];
  logic [CW-1:0]            quo_y_c [CW+1];

  lisect_pkg::lisect_ctrl_t fin;
  logic [CW-1:0]            q_x, q_y, lim_x, lim_y, mag_x, mag_y, res_x, res_y;
  logic                     ovf_x, ovf_y;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Capture, products, differences, magnitudes and range check.
  lisect_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .fy       (first_y_coef[CW-1:0]),
    .fx       (first_x_coef[CW-1:0]),
    .fb       (first_offset[CW-1:0]),
    .gy       (second_y_coef[CW-1:0]),
    .gx       (second_x_coef[CW-1:0]),
    .gb       (second_offset[CW-1:0]),
    .ctrl     (ctrl_c[0]),
    .den_mag  (den_c[0]),
    .rem_x    (rem_x_c[0]),
    .rem_y    (rem_y_c[0])
  );

  assign quo_x_c[0] = '0;
  assign quo_y_c[0] = '0;

  // Division chain, most significant quotient bit first.
  for (genvar k = 0; k < CW; k++) begin : g_cell
    lisect_cell #(
      .COEF_WIDTH (COEF_WIDTH),
      .MAG_W      (MAG_W),
      .REM_W      (REM_W),
      .BIT        (CW - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl_in   (ctrl_c[k]),
      .den_in    (den_c[k]),
      .rem_x_in  (rem_x_c[k]),
      .rem_y_in  (rem_y_c[k]),
      .quo_x_in  (quo_x_c[k]),
      .quo_y_in  (quo_y_c[k]),
      .ctrl_out  (ctrl_c[k+1]),
      .den_out   (den_c[k+1]),
      .rem_x_out (rem_x_c[k+1]),
      .rem_y_out (rem_y_c[k+1]),
      .quo_x_out (quo_x_c[k+1]),
      .quo_y_out (quo_y_c[k+1])
    );
  end

  // Saturation against the signed limit and sign restoration.
  always_comb begin
    fin   = ctrl_c[CW];
    q_x   = quo_x_c[CW];
    q_y   = quo_y_c[CW];
    lim_x = fin.neg_x ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - 1'b1);
    lim_y = fin.neg_y ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - 1'b1);
    ovf_x = fin.high_x || (q_x > lim_x);
    ovf_y = fin.high_y || (q_y > lim_y);
    mag_x = ovf_x ? lim_x : q_x;
    mag_y = ovf_y ? lim_y : q_y;
    res_x = fin.neg_x ? (~mag_x + 1'b1) : mag_x;
    res_y = fin.neg_y ? (~mag_y + 1'b1) : mag_y;
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    if (fin.parallel) begin
      cross_x     <= '0;
      cross_y     <= '0;
      is_parallel <= 1'b1;
      overflowed  <= 1'b0;
    end else begin
      cross_x     <= lisect_pkg::FIELD_W'($signed(res_x));
      cross_y     <= lisect_pkg::FIELD_W'($signed(res_y));
      is_parallel <= 1'b0;
      overflowed  <= ovf_x || ovf_y;
    end
  end

  // A result follows its request through the whole chain of cells.
  `LI_ASSERT_SAME(a_chain_latency, clk, rst, done, $past(ctrl_c[0].valid, CW + 1))
  // Parallel lines never report an overflow and always give the origin.
  `LI_ASSERT_SAME(a_parallel_clean, clk, rst, done && is_parallel, !overflowed && cross_x == '0 && cross_y == '0)
  // A valid item leaving the front end reaches the first cell output next cycle.
  `LI_ASSERT_NEXT(a_first_cell, clk, rst, ctrl_c[0].valid, ctrl_c[1].valid)

endmodule

[design/lisect_front.sv]
// Front end: cross products, differences, magnitudes and the quotient range check.
`timescale 1ns / 1ps

module lisect_front #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic signed [COEF_WIDTH-1:0]            fy,
  input  logic signed [COEF_WIDTH-1:0]            fx,
  input  logic signed [COEF_WIDTH-1:0]            fb,
  input  logic signed [COEF_WIDTH-1:0]            gy,
  input  logic signed [COEF_WIDTH-1:0]            gx,
  input  logic signed [COEF_WIDTH-1:0]            gb,
  output lisect_pkg::lisect_ctrl_t                ctrl,
  output logic [2*COEF_WIDTH-1:0]                 den_mag,
  output logic [2*COEF_WIDTH+((FRAC_BITS > COEF_WIDTH) ? FRAC_BITS : COEF_WIDTH)-1:0] rem_x,
  output logic [2*COEF_WIDTH+((FRAC_BITS > COEF_WIDTH) ? FRAC_BITS : COEF_WIDTH)-1:0] rem_y
);

  localparam int PROD_W = 2 * COEF_WIDTH;
  localparam int DIFF_W = PROD_W + 1;
  localparam int MAG_W  = 2 * COEF_WIDTH;
  localparam int EXT_W  = (FRAC_BITS > COEF_WIDTH) ? FRAC_BITS : COEF_WIDTH;
  localparam int REM_W  = MAG_W + EXT_W;

  // Stage 0: captured request.
  logic                         s0_valid;
  logic signed [COEF_WIDTH-1:0] s0_fy, s0_fx, s0_fb, s0_gy, s0_gx, s0_gb;

  // Stage 1: the six products.
  logic                     s1_valid;
  logic signed [PROD_W-1:0] p_gy_fb, p_fy_gb, p_fx_gb, p_gx_fb, p_fx_gy, p_gx_fy;

  // Stage 2: the three differences.
  logic                     s2_valid;
  logic signed [DIFF_W-1:0] d_nx, d_ny, d_den;

  // Stage 3: magnitudes and signs.
  logic             s3_valid;
  logic             s3_parallel, s3_neg_x, s3_neg_y;
  logic [MAG_W-1:0] s3_nx_mag, s3_ny_mag, s3_den_mag;

  logic [DIFF_W-1:0] abs_nx, abs_ny, abs_den;
  logic [REM_W-1:0]  div_x, div_y, den_top;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_valid;
    end
    s0_fy <= fy;
    s0_fx <= fx;
    s0_fb <= fb;
    s0_gy <= gy;
    s0_gx <= gx;
    s0_gb <= gb;
  end

  // Full-precision products, one multiplier each.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    p_gy_fb <= PROD_W'(s0_gy) * PROD_W'(s0_fb);
    p_fy_gb <= PROD_W'(s0_fy) * PROD_W'(s0_gb);
    p_fx_gb <= PROD_W'(s0_fx) * PROD_W'(s0_gb);
    p_gx_fb <= PROD_W'(s0_gx) * PROD_W'(s0_fb);
    p_fx_gy <= PROD_W'(s0_fx) * PROD_W'(s0_gy);
    p_gx_fy <= PROD_W'(s0_gx) * PROD_W'(s0_fy);
  end

  // Exact differences with one guard bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    d_nx  <= DIFF_W'(p_gy_fb) - DIFF_W'(p_fy_gb);
    d_ny  <= DIFF_W'(p_fx_gb) - DIFF_W'(p_gx_fb);
    d_den <= DIFF_W'(p_fx_gy) - DIFF_W'(p_gx_fy);
  end

  // Magnitudes always stay below 2^(2*COEF_WIDTH-1), so the guard bits drop out.
  always_comb begin
    abs_nx  = d_nx[DIFF_W-1]  ? (~d_nx + 1'b1)  : d_nx;
    abs_ny  = d_ny[DIFF_W-1]  ? (~d_ny + 1'b1)  : d_ny;
    abs_den = d_den[DIFF_W-1] ? (~d_den + 1'b1) : d_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_nx_mag   <= abs_nx[MAG_W-1:0];
    s3_ny_mag   <= abs_ny[MAG_W-1:0];
    s3_den_mag  <= abs_den[MAG_W-1:0];
    s3_parallel <= (abs_den[MAG_W-1:0] == '0);
    s3_neg_x    <= (d_nx[DIFF_W-1] ^ d_den[DIFF_W-1]) && (abs_nx[MAG_W-1:0] != '0);
    s3_neg_y    <= (d_ny[DIFF_W-1] ^ d_den[DIFF_W-1]) && (abs_ny[MAG_W-1:0] != '0);
  end

  // Scaled dividends, and a check that the quotient fits in COEF_WIDTH bits.
  always_comb begin
    div_x   = REM_W'(s3_nx_mag) << FRAC_BITS;
    div_y   = REM_W'(s3_ny_mag) << FRAC_BITS;
    den_top = REM_W'(s3_den_mag) << COEF_WIDTH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= s3_valid;
    end
    ctrl.parallel <= s3_parallel;
    ctrl.neg_x    <= s3_neg_x;
    ctrl.neg_y    <= s3_neg_y;
    ctrl.high_x   <= (div_x >= den_top);
    ctrl.high_y   <= (div_y >= den_top);
    den_mag       <= s3_den_mag;
    rem_x         <= div_x;
    rem_y         <= div_y;
  end

endmodule

[design/lisect_cell.sv]
// One restoring division cell: settles one quotient bit of both coordinates.
`timescale 1ns / 1ps

module lisect_cell #(
  parameter int COEF_WIDTH = 32,
  parameter int MAG_W      = 64,
  parameter int REM_W      = 96,
  parameter int BIT        = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lisect_pkg::lisect_ctrl_t  ctrl_in,
  input  logic [MAG_W-1:0]          den_in,
  input  logic [REM_W-1:0]          rem_x_in,
  input  logic [REM_W-1:0]          rem_y_in,
  input  logic [COEF_WIDTH-1:0]     quo_x_in,
  input  logic [COEF_WIDTH-1:0]     quo_y_in,
  output lisect_pkg::lisect_ctrl_t  ctrl_out,
  output logic [MAG_W-1:0]          den_out,
  output logic [REM_W-1:0]          rem_x_out,
  output logic [REM_W-1:0]          rem_y_out,
  output logic [COEF_WIDTH-1:0]     quo_x_out,
  output logic [COEF_WIDTH-1:0]     quo_y_out
);

  logic [REM_W-1:0]      den_sh;
  logic                  take_x, take_y;
  logic [REM_W-1:0]      rem_x_next, rem_y_next;
  logic [COEF_WIDTH-1:0] quo_x_next, quo_y_next;

  // Trial subtraction of the divisor aligned to this cell's quotient bit.
  always_comb begin
    den_sh     = REM_W'(den_in) << BIT;
    take_x     = (rem_x_in >= den_sh);
    take_y     = (rem_y_in >= den_sh);
    rem_x_next = take_x ? (rem_x_in - den_sh) : rem_x_in;
    rem_y_next = take_y ? (rem_y_in - den_sh) : rem_y_in;
    quo_x_next = quo_x_in;
    quo_y_next = quo_y_in;
    quo_x_next[BIT] = take_x;
    quo_y_next[BIT] = take_y;
  end

  // Hand everything on to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.parallel <= ctrl_in.parallel;
    ctrl_out.neg_x    <= ctrl_in.neg_x;
    ctrl_out.neg_y    <= ctrl_in.neg_y;
    ctrl_out.high_x   <= ctrl_in.high_x;
    ctrl_out.high_y   <= ctrl_in.high_y;
    den_out   <= den_in;
    rem_x_out <= rem_x_next;
    rem_y_out <= rem_y_next;
    quo_x_out <= quo_x_next;
    quo_y_out <= quo_y_next;
  end

endmodule

[test/tb_line_intersection.sv]
// Self-checking testbench for the fixed-point two-line intersection unit.
`timescale 1ns / 1ps

module tb_line_intersection;

  typedef logic signed [lisect_pkg::FIELD_W-1:0] coef_t;

  // One request: two lines, each written as a1*y + a2*x = b.
  typedef struct packed {
    coef_t fy;
    coef_t fx;
    coef_t fb;
    coef_t gy;
    coef_t gx;
    coef_t gb;
  } line_pair_t;

  // One crossing point as the block reports it.
  typedef struct {
    coef_t x;
    coef_t y;
    logic  par;
    logic  ovf;
  } crossing_t;

  localparam int    WATCHDOG_LIMIT = 1000;
  localparam int    DRAIN_CYCLES   = 45;
  localparam coef_t MOST_NEG       = 32'sh8000_0000;
  localparam coef_t MOST_POS       = 32'sh7fff_ffff;
  localparam coef_t ONE            = 32'sh0001_0000;

  // Holds the crossing points still owed by the block and checks each result.
  class crossing_scoreboard;
    crossing_t pending[$];
    int        mismatches;
    int        checked;
    int        parallel_seen;
    int        saturated_seen;

    // Exact p*q - r*s, held at 66 bits so that no cross-product difference wraps.
    function logic signed [65:0] cross_diff(longint u, longint w);
      return {{2{u[63]}}, u} - {{2{w[63]}}, w};
    endfunction

    // Quotient (num << 16) / den truncated toward zero; the top bit flags saturation.
    function logic [32:0] fixed_quotient(logic signed [65:0] num, logic signed [65:0] den);
      logic [65:0] num_mag;
      logic [65:0] den_mag;
      logic [81:0] quo;
      logic [81:0] lim;
      logic        neg;
      num_mag = num[65] ? 66'(-num) : 66'(num);
      den_mag = den[65] ? 66'(-den) : 66'(den);
      neg = (num[65] != den[65]) && (num_mag != 0);
      quo = {num_mag, 16'h0} / {16'h0, den_mag};
      lim = neg ? 82'h8000_0000 : 82'h7fff_ffff;
      if (quo > lim) begin
        return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
      end
      return {1'b0, neg ? 32'(-quo[31:0]) : quo[31:0]};
    endfunction

    // Works out the crossing point by Cramer's rule.
    function crossing_t predict_crossing(line_pair_t p);
      logic signed [65:0] num_x;
      logic signed [65:0] num_y;
      logic signed [65:0] den;
      logic [32:0]        qx;
      logic [32:0]        qy;
      crossing_t          r;
      num_x = cross_diff(longint'(p.gy) * longint'(p.fb), longint'(p.fy) * longint'(p.gb));
      num_y = cross_diff(longint'(p.fx) * longint'(p.gb), longint'(p.gx) * longint'(p.fb));
      den   = cross_diff(longint'(p.fx) * longint'(p.gy), longint'(p.gx) * longint'(p.fy));
      if (den == 0) begin
        r.x   = '0;
        r.y   = '0;
        r.par = 1'b1;
        r.ovf = 1'b0;
        return r;
      end
      qx = fixed_quotient(num_x, den);
      qy = fixed_quotient(num_y, den);
      r.x   = qx[31:0];
      r.y   = qy[31:0];
      r.par = 1'b0;
      r.ovf = qx[32] | qy[32];
      return r;
    endfunction

    // Notes an accepted request and queues the crossing point it must give.
    function void note_request(line_pair_t p);
      crossing_t r;
      r = predict_crossing(p);
      if (r.par) parallel_seen++;
      if (r.ovf) saturated_seen++;
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch at result %0d, %s: got %0h, expected %0h", checked, what, got, want);
      mismatches++;
    endtask

    // Compares one result with the oldest crossing point still owed.
    task check_result(coef_t x, coef_t y, logic par, logic ovf);
      crossing_t want;
      if (pending.size() == 0) begin
        report("result with no request outstanding", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (x !== want.x) report("cross_x", 32'(x), 32'(want.x));
      if (y !== want.y) report("cross_y", 32'(y), 32'(want.y));
      if (par !== want.par) report("is_parallel", par, want.par);
      if (ovf !== want.ovf) report("overflowed", ovf, want.ovf);
      checked++;
    endtask
  endclass

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  coef_t first_y_coef;
  coef_t first_x_coef;
  coef_t first_offset;
  coef_t second_y_coef;
  coef_t second_x_coef;
  coef_t second_offset;
  logic  done;
  coef_t cross_x;
  coef_t cross_y;
  logic  is_parallel;
  logic  overflowed;

  crossing_scoreboard sb = new();
  int                 quiet_cycles = 0;
  int                 requests_sent;

  line_intersection DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_y_coef (first_y_coef),
    .first_x_coef (first_x_coef),
    .first_offset (first_offset),
    .second_y_coef(second_y_coef),
    .second_x_coef(second_x_coef),
    .second_offset(second_offset),
    .done         (done),
    .cross_x      (cross_x),
    .cross_y      (cross_y),
    .is_parallel  (is_parallel),
    .overflowed   (overflowed)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Results are checked on the edge that ends their single valid cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(cross_x, cross_y, is_parallel, overflowed);
    end
  end

  // The run is abandoned if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic line_pair_t make_pair(coef_t fy, coef_t fx, coef_t fb,
                                           coef_t gy, coef_t gx, coef_t gb);
    line_pair_t p;
    p.fy = fy;
    p.fx = fx;
    p.fb = fb;
    p.gy = gy;
    p.gx = gx;
    p.gb = gb;
    return p;
  endfunction

  function automatic coef_t full_random();
    return coef_t'($urandom);
  endfunction

  // Values of the size that real line coefficients tend to have.
  function automatic coef_t moderate();
    logic [23:0] r;
    r = 24'($urandom);
    return {{8{r[23]}}, r};
  endfunction

  function automatic coef_t corner_value();
    case ($urandom_range(0, 7))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return ONE;
      6: return -ONE;
      default: return MOST_NEG + 32'sd1;
    endcase
  endfunction

  // Random line pairs, with realistic, parallel, near-parallel, saturating and extreme mixes.
  function automatic line_pair_t random_pair();
    line_pair_t p;
    coef_t      k;
    p = make_pair(full_random(), full_random(), full_random(),
                  full_random(), full_random(), full_random());
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3: p = make_pair(moderate(), moderate(), moderate(),
                          moderate(), moderate(), moderate());
      4: begin
        // One line a whole multiple of the other, sometimes the same line.
        k = coef_t'($urandom_range(0, 8)) - 32'sd4;
        p.fy = moderate();
        p.fx = moderate();
        p.fb = moderate();
        p.gy = k * p.fy;
        p.gx = k * p.fx;
        if ($urandom_range(0, 1)) p.gb = k * p.fb;
      end
      5: begin
        // Tiny denominator against large offsets.
        p.fy = coef_t'($urandom_range(0, 4)) - 32'sd2;
        p.gx = coef_t'($urandom_range(0, 4)) - 32'sd2;
        p.fx = coef_t'($urandom_range(0, 2)) - 32'sd1;
        p.gy = coef_t'($urandom_range(0, 2)) - 32'sd1;
      end
      6: p = make_pair(corner_value(), corner_value(), corner_value(),
                       corner_value(), corner_value(), corner_value());
      7: begin
        // Nearly parallel lines.
        p.gy = p.fy;
        p.gx = p.fx + coef_t'($urandom_range(0, 32)) - 32'sd16;
      end
      8: begin
        if ($urandom_range(0, 1)) p.fy = '0;
        if ($urandom_range(0, 1)) p.fx = '0;
        if ($urandom_range(0, 1)) p.gy = '0;
        if ($urandom_range(0, 1)) p.gx = '0;
        if ($urandom_range(0, 1)) p.fb = '0;
        if ($urandom_range(0, 1)) p.gb = '0;
      end
      default: begin
        // Axis-aligned lines, whose coordinates can lie anywhere in their range, at times right at its edge.
        p.fy = $urandom_range(0, 1) ? ONE : -ONE;
        p.gx = $urandom_range(0, 1) ? ONE : -ONE;
        p.fx = '0;
        p.gy = '0;
        if ($urandom_range(0, 1)) p.gb = corner_value();
      end
    endcase
    return p;
  endfunction

  // Presents one request and waits until the block takes it.
  task automatic send_pair(line_pair_t p);
    start         <= 1'b1;
    first_y_coef  <= p.fy;
    first_x_coef  <= p.fx;
    first_offset  <= p.fb;
    second_y_coef <= p.gy;
    second_x_coef <= p.gx;
    second_offset <= p.gb;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(p);
    requests_sent++;
  endtask

  // Leaves start low and puts junk on the coefficient ports.
  task automatic idle_gap(int cycles);
    start <= 1'b0;
    for (int i = 0; i < cycles; i++) begin
      first_y_coef  <= full_random();
      first_x_coef  <= full_random();
      first_offset  <= full_random();
      second_y_coef <= full_random();
      second_x_coef <= full_random();
      second_offset <= full_random();
      @(posedge clk);
    end
  endtask

  task automatic run_random(int count, int gap_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < gap_pct) idle_gap($urandom_range(1, 6));
      send_pair(random_pair());
    end
  endtask

  // Hand-picked cases: extremes, parallel and identical lines, truncation and saturation.
  task automatic run_directed();
    send_pair(make_pair('0, '0, '0, '0, '0, '0));
    send_pair(make_pair(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
    send_pair(make_pair(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS));
    send_pair(make_pair(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
    send_pair(make_pair(ONE, '0, 2 * ONE, '0, ONE, 3 * ONE));
    send_pair(make_pair(ONE, '0, -32'sh28000, '0, ONE, -32'sh18000));
    send_pair(make_pair(3 * ONE, '0, ONE, '0, 3 * ONE, -ONE));
    send_pair(make_pair(ONE, '0, 32'sh12345, '0, ONE, MOST_NEG));
    send_pair(make_pair(ONE, '0, '0, '0, -ONE, MOST_NEG));
    send_pair(make_pair(ONE, '0, MOST_POS, '0, ONE, MOST_POS));
    send_pair(make_pair(32'sd1, '0, '0, '0, 32'sd1, MOST_POS));
    send_pair(make_pair(32'sd1, '0, 32'sd5, '0, 32'sd1, -MOST_POS));
    send_pair(make_pair(32'sd1, '0, '0, '0, 32'sd1, '0));
    send_pair(make_pair(MOST_NEG, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS));
    send_pair(make_pair(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG));
    send_pair(make_pair(2 * ONE, 3 * ONE, 5 * ONE, 2 * ONE, 3 * ONE, 5 * ONE));
    send_pair(make_pair(ONE, ONE, '0, 2 * ONE, 2 * ONE, 7 * ONE));
    send_pair(make_pair('0, 32'sd1, 32'sh7fff, 32'sd1, '0, -32'sd3));
    send_pair(make_pair('0, ONE, 4 * ONE, ONE, ONE, '0));
    send_pair(make_pair(MOST_NEG, '0, '0, '0, MOST_NEG, '0));
  endtask

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    first_y_coef  <= '0;
    first_x_coef  <= '0;
    first_offset  <= '0;
    second_y_coef <= '0;
    second_x_coef <= '0;
    second_offset <= '0;
    requests_sent  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After the directed cases the sender idles often, then mostly, then never.
    run_directed();
    run_random(410, 22);
    run_random(410, 70);
    run_random(410, 0);
    start <= 1'b0;

    // Let every owed result arrive, then watch a little longer for strays.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d crossing points.", requests_sent, sb.checked);
    $display("Among them %0d parallel pairs and %0d saturated results; %0d mismatches.",
             sb.parallel_seen, sb.saturated_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
